FILE: sv/cic_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded interrupt controller package
// Transfer types, per-chip register set, command codes and priority helpers.
// ----------------------------------------------------------------------------
package cic_pkg;

   localparam int LINES_PER_CHIP = 8;
   localparam int LINE_W         = $clog2(LINES_PER_CHIP);
   localparam int CHIP_COUNT     = 2;
   localparam int ALL_LINES      = LINES_PER_CHIP * CHIP_COUNT;
   localparam logic [LINE_W:0] NO_LINE = LINE_W'(0) | (LINE_W+1)'(LINES_PER_CHIP);

   // Master request line driven by the slave output.
   localparam logic [LINE_W-1:0] CASCADE_LINE = LINE_W'(2);

   // Request types.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_IRQ   = 2'd2;
   localparam logic [1:0] REQ_ACK   = 2'd3;

   // Port select codes.
   localparam logic PORT_CMD  = 1'b0;
   localparam logic PORT_DATA = 1'b1;

   // Initialization sequencer codes.
   localparam logic [1:0] STAGE_READY = 2'd0;
   localparam logic [1:0] STAGE_ICW2  = 2'd1;
   localparam logic [1:0] STAGE_ICW3  = 2'd2;
   localparam logic [1:0] STAGE_ICW4  = 2'd3;

   // Command byte decode.
   localparam int CMD_ICW1_BIT    = 4;
   localparam int CMD_OCW3_BIT    = 3;
   localparam int OCW3_RR_BIT     = 1;
   localparam int OCW3_RIS_BIT    = 0;
   localparam int FLAG_IC4_BIT    = 0;
   localparam int FLAG_SNGL_BIT   = 1;
   localparam logic [2:0] EOI_NONSPECIFIC = 3'd1;
   localparam logic [2:0] EOI_SPECIFIC    = 3'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        chip_select;
      logic        port_select;
      logic [7:0]  write_data;
      logic [15:0] irq_lines;
   } cic_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       int_pending;
      logic [7:0] vector;
      logic       vector_valid;
   } cic_rsp_type;

   typedef struct packed {
      logic [LINES_PER_CHIP-1:0] request;
      logic [LINES_PER_CHIP-1:0] service;
      logic [LINES_PER_CHIP-1:0] mask;
      logic [4:0]                base;
      logic [7:0]                cascade_word;
      logic [7:0]                mode_word;
      logic [1:0]                stage;
      logic [1:0]                flags;
      logic                      sel_isr;
   } cic_chip_type;

   // Acknowledge command from the top level to one chip.
   typedef struct packed {
      logic              enable;
      logic [LINE_W-1:0] line;
   } cic_ack_type;

   // Lowest set bit, line 0 has the highest priority; NO_LINE when empty.
   function automatic logic [LINE_W:0] lowest_bit(input logic [LINES_PER_CHIP-1:0] v);
      logic [LINE_W:0] idx;
      idx = NO_LINE;
      for (int i = LINES_PER_CHIP - 1; i >= 0; i--) begin
         if (v[i]) idx = (LINE_W+1)'(i);
      end
      return idx;
   endfunction

   // Line the chip would hand out now: only if strictly above every in-service line.
   function automatic logic [LINE_W:0] pending_line(input cic_chip_type s);
      logic [LINE_W:0] req;
      logic [LINE_W:0] svc;
      req = lowest_bit(s.request & ~s.mask);
      svc = lowest_bit(s.service);
      if (req == NO_LINE || req >= svc) return NO_LINE;
      return req;
   endfunction

endpackage

FILE: sv/cic_chip.sv
// ----------------------------------------------------------------------------
// Cascaded interrupt controller chip
// Next-state logic of one controller: ICW/OCW decode, mask, edge latch,
// acknowledge marking and the bus read multiplexer.
// ----------------------------------------------------------------------------
module cic_chip (
   input  cic_pkg::cic_chip_type             state_ff,
   input  cic_pkg::cic_req_type              item,
   input  logic                              selected,
   input  logic [cic_pkg::LINES_PER_CHIP-1:0] rise,
   input  cic_pkg::cic_ack_type              ack,
   output cic_pkg::cic_chip_type             state_in,
   output logic [7:0]                        read_data
);
   import cic_pkg::*;

   logic [7:0] d;

   assign d = item.write_data;

   always_comb begin
      state_in = state_ff;
      case (item.req_type)
         REQ_WRITE: begin
            if (selected) begin
               if (item.port_select == PORT_CMD) begin
                  if (d[CMD_ICW1_BIT]) begin
                     state_in.flags     = d[1:0];
                     state_in.mask      = '0;
                     state_in.request   = '0;
                     state_in.service   = '0;
                     state_in.mode_word = '0;
                     state_in.sel_isr   = 1'b0;
                     state_in.stage     = STAGE_ICW2;
                  end else if (d[CMD_OCW3_BIT]) begin
                     if (d[OCW3_RR_BIT]) state_in.sel_isr = d[OCW3_RIS_BIT];
                  end else if (d[7:5] == EOI_NONSPECIFIC) begin
                     // Clearing the lowest set bit drops the highest-priority line.
                     state_in.service = state_ff.service & (state_ff.service - 1'b1);
                  end else if (d[7:5] == EOI_SPECIFIC) begin
                     state_in.service[d[LINE_W-1:0]] = 1'b0;
                  end
               end else begin
                  case (state_ff.stage)
                     STAGE_ICW2: begin
                        state_in.base = d[7:3];
                        if (state_ff.flags[FLAG_SNGL_BIT]) begin
                           state_in.stage = state_ff.flags[FLAG_IC4_BIT] ? STAGE_ICW4
                                                                         : STAGE_READY;
                        end else begin
                           state_in.stage = STAGE_ICW3;
                        end
                     end
                     STAGE_ICW3: begin
                        state_in.cascade_word = d;
                        state_in.stage = state_ff.flags[FLAG_IC4_BIT] ? STAGE_ICW4
                                                                      : STAGE_READY;
                     end
                     STAGE_ICW4: begin
                        state_in.mode_word = d;
                        state_in.stage     = STAGE_READY;
                     end
                     default: begin
                        state_in.mask = d;
                     end
                  endcase
               end
            end
         end
         REQ_IRQ: begin
            state_in.request = state_ff.request | rise;
         end
         REQ_ACK: begin
            if (ack.enable) begin
               state_in.request[ack.line] = 1'b0;
               state_in.service[ack.line] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (item.port_select == PORT_DATA) read_data = state_ff.mask;
      else if (state_ff.sel_isr)         read_data = state_ff.service;
      else                               read_data = state_ff.request;
   end

endmodule

FILE: sv/cascaded_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// Cascaded interrupt controller core
// Master and slave controller pair with edge-triggered fixed-priority requests.
// ----------------------------------------------------------------------------
// Every transfer on req is captured in an input register; from that register
// the register update of both chips, the cascade edge check and the response
// are computed together and the response is loaded into the output register.
// A new request transfer is taken every cycle while req_stall is low; req_stall
// rises only while both the input and output registers are full and rsp_stall
// holds the response. Slave output always feeds master line 2.
module cascaded_interrupt_controller_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cic_pkg::cic_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cic_pkg::cic_rsp_type rsp_data
);
   import cic_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   cic_req_type            item_ff;
   logic                   out_valid_ff, out_valid_in;
   cic_rsp_type            rsp_ff, rsp_in;
   cic_chip_type           master_ff, slave_ff;
   cic_chip_type           master_in, slave_in;
   cic_chip_type           master_next, slave_next;
   logic [ALL_LINES-1:0]   prev_ff, prev_in;
   logic [ALL_LINES-1:0]   prev_step;
   logic                   advance;
   logic                   take;
   logic [LINE_W:0]        master_line, slave_line;
   cic_ack_type            master_ack, slave_ack;
   logic [ALL_LINES-1:0]   rise;
   logic [LINES_PER_CHIP-1:0] master_rise;
   logic [7:0]             master_rd, slave_rd;
   logic                   slave_out;
   logic                   is_ack;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = (in_valid_ff && advance) || (out_valid_ff && rsp_stall);

   // Acknowledge selection from the registered state.
   assign is_ack      = (item_ff.req_type == REQ_ACK);
   assign master_line = pending_line(master_ff);
   assign slave_line  = pending_line(slave_ff);
   assign master_ack.enable = is_ack && (master_line != NO_LINE);
   assign master_ack.line   = master_line[LINE_W-1:0];
   assign slave_ack.enable  = master_ack.enable && (master_line[LINE_W-1:0] == CASCADE_LINE)
                              && (slave_line != NO_LINE);
   assign slave_ack.line    = slave_line[LINE_W-1:0];

   assign rise        = item_ff.irq_lines & ~prev_ff;
   assign master_rise = rise[LINES_PER_CHIP-1:0] & ~(LINES_PER_CHIP'(1) << CASCADE_LINE);

   cic_chip u_master (
      .state_ff  (master_ff),
      .item      (item_ff),
      .selected  (item_ff.chip_select == 1'b0),
      .rise      (master_rise),
      .ack       (master_ack),
      .state_in  (master_next),
      .read_data (master_rd)
   );

   cic_chip u_slave (
      .state_ff  (slave_ff),
      .item      (item_ff),
      .selected  (item_ff.chip_select == 1'b1),
      .rise      (rise[ALL_LINES-1:LINES_PER_CHIP]),
      .ack       (slave_ack),
      .state_in  (slave_next),
      .read_data (slave_rd)
   );

   // Line history; the cascade bit keeps the last slave output.
   always_comb begin
      prev_step = prev_ff;
      if (item_ff.req_type == REQ_IRQ) begin
         prev_step = item_ff.irq_lines;
         prev_step[CASCADE_LINE] = prev_ff[CASCADE_LINE];
      end
   end

   // A rising slave output latches the master cascade request.
   always_comb begin
      slave_out = (pending_line(slave_next) != NO_LINE);
      master_in = master_next;
      slave_in  = slave_next;
      prev_in   = prev_step;
      if (slave_out && !prev_step[CASCADE_LINE]) master_in.request[CASCADE_LINE] = 1'b1;
      prev_in[CASCADE_LINE] = slave_out;
   end

   always_comb begin
      rsp_in = '0;
      if (item_ff.req_type == REQ_READ) begin
         rsp_in.read_data = item_ff.chip_select ? slave_rd : master_rd;
      end
      if (is_ack) begin
         if (!master_ack.enable) begin
            rsp_in.vector = {master_ff.base, {LINE_W{1'b1}}};
         end else if (master_line[LINE_W-1:0] == CASCADE_LINE) begin
            if (slave_ack.enable) begin
               rsp_in.vector       = {slave_ff.base, slave_line[LINE_W-1:0]};
               rsp_in.vector_valid = 1'b1;
            end else begin
               rsp_in.vector = {slave_ff.base, {LINE_W{1'b1}}};
            end
         end else begin
            rsp_in.vector       = {master_ff.base, master_line[LINE_W-1:0]};
            rsp_in.vector_valid = 1'b1;
         end
      end
      rsp_in.int_pending = (pending_line(master_in) != NO_LINE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         master_ff    <= '0;
         slave_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_valid_ff && advance) begin
            master_ff <= master_in;
            slave_ff  <= slave_in;
            prev_ff   <= prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) item_ff <= req_data;
      if (in_valid_ff && advance) rsp_ff <= rsp_in;
   end

endmodule

FILE: sv/cic_checker.sv
// ----------------------------------------------------------------------------
// Cascaded interrupt controller checker
// Port-level assertions, attached to the core by a bind statement.
// ----------------------------------------------------------------------------
module cic_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input cic_pkg::cic_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cic_pkg::cic_rsp_type rsp_data
);

   // A held response stays put until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A stalled request stays put until its transfer.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // The request side only waits behind a full response register.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty response register");

   // Reset leaves no response behind.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A real vector comes only from an acknowledge, never with read data.
   a_vector_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vector_valid |-> rsp_data.read_data == 8'd0)
      else $error("vector and read data in the same response");

endmodule

bind cascaded_interrupt_controller_core cic_checker u_cic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cascaded interrupt controller core testbench
// Drives bus writes, bus reads, request line samples and acknowledges through
// the valid/stall request channel, predicts every response with an internal
// model of the master/slave pair, and compares each response transfer field
// by field. The sender and receiver idle at random in the first two thirds of
// the run and run without gaps in the last third.
// ----------------------------------------------------------------------------
module testbench;
   import cic_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int RANDOM_ITEMS  = 650;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 20;
   localparam int NO_REQUEST    = LINES_PER_CHIP;

   localparam logic MASTER = 1'b0;
   localparam logic SLAVE  = 1'b1;

   localparam logic [7:0]  ICW1_START        = 8'h10;
   localparam logic [7:0]  ICW1_IC4          = 8'h01;
   localparam logic [7:0]  ICW1_SNGL         = 8'h02;
   localparam logic [7:0]  OCW3_READ_IRR     = 8'h0a;
   localparam logic [7:0]  OCW3_READ_ISR     = 8'h0b;
   localparam logic [7:0]  OCW3_NO_READ_SEL  = 8'h09;
   localparam logic [7:0]  EOI_NONSPEC_CMD   = 8'h20;
   localparam logic [7:0]  EOI_SPEC_CMD      = 8'h60;
   localparam logic [7:0]  OCW2_SET_PRIORITY = 8'hc0;
   localparam logic [7:0]  ALL_MASKED        = 8'hff;
   localparam logic [7:0]  NONE_MASKED       = 8'h00;
   localparam logic [2:0]  SPURIOUS_LINE     = 3'd7;
   localparam logic [15:0] CASCADE_MASK      = 16'(1) << CASCADE_LINE;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cic_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cic_rsp_type rsp_data;

   cic_req_type req_backlog[$];
   cic_rsp_type expected_rsps[$];
   cic_rsp_type predicted_rsp;
   cic_rsp_type expected_rsp;

   int sent_count  = 0;
   int total_items = 0;
   int failures    = 0;
   int cycle_count = 0;

   // Model of both chips.
   logic [7:0]  model_irr[2];
   logic [7:0]  model_isr[2];
   logic [7:0]  model_imr[2];
   logic [7:0]  model_cascade_word[2];
   logic [7:0]  model_mode_word[2];
   logic [4:0]  model_base[2];
   logic [1:0]  model_stage[2];
   logic [1:0]  model_flags[2];
   logic        model_sel_isr[2];
   logic [15:0] model_prev_lines;

   cascaded_interrupt_controller_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int first_set(input logic [7:0] pattern);
      for (int i = 0; i < LINES_PER_CHIP; i++) begin
         if (pattern[i]) return i;
      end
      return NO_REQUEST;
   endfunction

   // A request is handed out only when it outranks every line in service.
   function automatic int ready_line(input int c);
      int req;
      int svc;
      req = first_set(model_irr[c] & ~model_imr[c]);
      svc = first_set(model_isr[c]);
      if (req == NO_REQUEST || req >= svc) return NO_REQUEST;
      return req;
   endfunction

   task automatic pic_pair_step(input cic_req_type item, output cic_rsp_type rsp);
      int          c;
      int          m;
      int          s;
      logic [7:0]  d;
      logic [15:0] rise;
      logic        slave_out;
      rsp = '0;
      c = int'(item.chip_select);
      d = item.write_data;
      case (item.req_type)
         REQ_WRITE: begin
            if (item.port_select == PORT_DATA) begin
               case (model_stage[c])
                  STAGE_ICW2: begin
                     model_base[c] = d[7:3];
                     if (model_flags[c][FLAG_SNGL_BIT])
                        model_stage[c] = model_flags[c][FLAG_IC4_BIT] ? STAGE_ICW4 : STAGE_READY;
                     else
                        model_stage[c] = STAGE_ICW3;
                  end
                  STAGE_ICW3: begin
                     model_cascade_word[c] = d;
                     model_stage[c] = model_flags[c][FLAG_IC4_BIT] ? STAGE_ICW4 : STAGE_READY;
                  end
                  STAGE_ICW4: begin
                     model_mode_word[c] = d;
                     model_stage[c] = STAGE_READY;
                  end
                  default: model_imr[c] = d;
               endcase
            end else if (d[CMD_ICW1_BIT]) begin
               model_flags[c]   = d[1:0];
               model_imr[c]     = '0;
               model_irr[c]     = '0;
               model_isr[c]     = '0;
               model_mode_word[c] = '0;
               model_sel_isr[c] = 1'b0;
               model_stage[c]   = STAGE_ICW2;
            end else if (d[CMD_OCW3_BIT]) begin
               if (d[OCW3_RR_BIT]) model_sel_isr[c] = d[OCW3_RIS_BIT];
            end else begin
               case (d[7:5])
                  EOI_NONSPECIFIC: begin
                     s = first_set(model_isr[c]);
                     if (s != NO_REQUEST) model_isr[c][s] = 1'b0;
                  end
                  EOI_SPECIFIC: model_isr[c][d[2:0]] = 1'b0;
                  default: ;
               endcase
            end
         end
         REQ_READ: begin
            if (item.port_select == PORT_DATA)
               rsp.read_data = model_imr[c];
            else
               rsp.read_data = model_sel_isr[c] ? model_isr[c] : model_irr[c];
         end
         REQ_IRQ: begin
            // The cascade line is not an external input: it keeps the last slave output.
            rise = item.irq_lines & ~model_prev_lines;
            model_irr[0] = model_irr[0] | (rise[7:0] & ~CASCADE_MASK[7:0]);
            model_irr[1] = model_irr[1] | rise[15:8];
            model_prev_lines = (item.irq_lines & ~CASCADE_MASK)
                             | (model_prev_lines & CASCADE_MASK);
         end
         default: begin
            m = ready_line(0);
            if (m == NO_REQUEST) begin
               rsp.vector = {model_base[0], SPURIOUS_LINE};
            end else begin
               model_irr[0][m] = 1'b0;
               model_isr[0][m] = 1'b1;
               if (m == int'(CASCADE_LINE)) begin
                  s = ready_line(1);
                  if (s == NO_REQUEST) begin
                     rsp.vector = {model_base[1], SPURIOUS_LINE};
                  end else begin
                     model_irr[1][s] = 1'b0;
                     model_isr[1][s] = 1'b1;
                     rsp.vector = {model_base[1], 3'(s)};
                     rsp.vector_valid = 1'b1;
                  end
               end else begin
                  rsp.vector = {model_base[0], 3'(m)};
                  rsp.vector_valid = 1'b1;
               end
            end
         end
      endcase
      slave_out = ready_line(1) != NO_REQUEST;
      if (slave_out && !model_prev_lines[CASCADE_LINE]) model_irr[0][CASCADE_LINE] = 1'b1;
      model_prev_lines[CASCADE_LINE] = slave_out;
      rsp.int_pending = ready_line(0) != NO_REQUEST;
   endtask

   task automatic queue_req(input logic [1:0] kind, input logic chip, input logic port,
                            input logic [7:0] data, input logic [15:0] lines);
      cic_req_type item;
      item.req_type    = kind;
      item.chip_select = chip;
      item.port_select = port;
      item.write_data  = data;
      item.irq_lines   = lines;
      req_backlog.push_back(item);
   endtask

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   // Idle percentages by run phase: receiver-heavy, then sender-heavy, then none.
   function automatic int idle_pct(input logic receiver_side);
      int phase;
      phase = (total_items == 0) ? 0 : sent_count * 3 / total_items;
      case (phase)
         0: return receiver_side ? 66 : 38;
         1: return receiver_side ? 38 : 66;
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pic_pair_step(req_data, predicted_rsp);
            expected_rsps.push_back(predicted_rsp);
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               req_data   <= req_backlog.pop_front();
               req_valid  <= 1'b1;
               sent_count <= sent_count + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               log_failure($sformatf("unexpected response: rd %h int %b vec %h ok %b",
                  rsp_data.read_data, rsp_data.int_pending, rsp_data.vector,
                  rsp_data.vector_valid));
            end else begin
               expected_rsp = expected_rsps.pop_front();
               if (rsp_data.read_data !== expected_rsp.read_data ||
                   rsp_data.int_pending !== expected_rsp.int_pending ||
                   rsp_data.vector !== expected_rsp.vector ||
                   rsp_data.vector_valid !== expected_rsp.vector_valid)
                  log_failure($sformatf(
                     "mismatch: expected rd %h int %b vec %h ok %b, got rd %h int %b vec %h ok %b",
                     expected_rsp.read_data, expected_rsp.int_pending, expected_rsp.vector,
                     expected_rsp.vector_valid, rsp_data.read_data, rsp_data.int_pending,
                     rsp_data.vector, rsp_data.vector_valid));
            end
         end
         rsp_stall <= $urandom_range(99) < idle_pct(1'b1);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int         pick;
      int         data_writes;
      logic       chip;
      logic [7:0] icw1;
      for (int c = 0; c < CHIP_COUNT; c++) begin
         model_irr[c]          = '0;
         model_isr[c]          = '0;
         model_imr[c]          = '0;
         model_cascade_word[c] = '0;
         model_mode_word[c]    = '0;
         model_base[c]         = '0;
         model_stage[c]        = STAGE_READY;
         model_flags[c]        = '0;
         model_sel_isr[c]      = 1'b0;
      end
      model_prev_lines = '0;

      // Directed part. Acknowledge before any setup gives the spurious vector of base zero.
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      // Master with ICW4; a read-select command in the middle of initialization.
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  ICW1_START | ICW1_IC4, '0);
      queue_req(REQ_WRITE, MASTER, PORT_DATA, 8'h20, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  OCW3_READ_ISR, '0);
      queue_req(REQ_WRITE, MASTER, PORT_DATA, 8'h04, '0);
      queue_req(REQ_WRITE, MASTER, PORT_DATA, 8'h01, '0);
      // Slave in single mode: first with ICW4 only, then with neither ICW3 nor ICW4.
      queue_req(REQ_WRITE, SLAVE,  PORT_CMD,  ICW1_START | ICW1_SNGL | ICW1_IC4, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, 8'hff, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, 8'hff, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_CMD,  ICW1_START | ICW1_SNGL, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, 8'h28, '0);
      // All lines rise; the cascade bit of the sample is ignored.
      queue_req(REQ_IRQ,   MASTER, PORT_CMD,  '0, 16'hffff);
      queue_req(REQ_READ,  MASTER, PORT_CMD,  '0, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  OCW3_READ_IRR, '0);
      queue_req(REQ_READ,  MASTER, PORT_CMD,  '0, '0);
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      // Line 1 does not outrank line 0 in service, so this one is spurious.
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  EOI_NONSPEC_CMD, '0);
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  EOI_SPEC_CMD | 8'h01, '0);
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      // Slave output rises again while unmasked and is then masked off, so the master takes the cascade
      // line with nothing left on the slave.
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, ALL_MASKED, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_CMD,  EOI_NONSPEC_CMD, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, NONE_MASKED, '0);
      queue_req(REQ_WRITE, SLAVE,  PORT_DATA, ALL_MASKED, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  EOI_SPEC_CMD | 8'h02, '0);
      queue_req(REQ_ACK,   MASTER, PORT_CMD,  '0, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  OCW2_SET_PRIORITY, '0);
      queue_req(REQ_WRITE, MASTER, PORT_CMD,  OCW3_NO_READ_SEL, '0);
      queue_req(REQ_IRQ,   SLAVE,  PORT_DATA, '0, 16'h0000);
      queue_req(REQ_READ,  SLAVE,  PORT_DATA, '0, '0);

      total_items = req_backlog.size() + RANDOM_ITEMS;
      while (req_backlog.size() < total_items) begin
         pick = $urandom_range(99);
         chip = 1'($urandom_range(1));
         if (pick < 8) begin
            // Initialization sequence, now and then cut short or interrupted.
            icw1 = 8'($urandom) | ICW1_START;
            data_writes = 1 + (icw1[FLAG_SNGL_BIT] ? 0 : 1) + (icw1[FLAG_IC4_BIT] ? 1 : 0);
            queue_req(REQ_WRITE, chip, PORT_CMD, icw1, 16'($urandom));
            if ($urandom_range(4) == 0) begin
               data_writes = $urandom_range(data_writes);
               queue_req(REQ_WRITE, chip, PORT_CMD,
                         {3'($urandom), 1'b0, 1'b1, 3'($urandom)}, 16'($urandom));
            end
            for (int i = 0; i < data_writes; i++)
               queue_req(REQ_WRITE, chip, PORT_DATA, 8'($urandom), 16'($urandom));
         end else if (pick < 38) begin
            case ($urandom_range(9))
               0: queue_req(REQ_IRQ, chip, 1'($urandom_range(1)), 8'($urandom), 16'h0000);
               1: queue_req(REQ_IRQ, chip, 1'($urandom_range(1)), 8'($urandom), 16'hffff);
               default: queue_req(REQ_IRQ, chip, 1'($urandom_range(1)), 8'($urandom),
                                  16'($urandom) & 16'($urandom));
            endcase
         end else if (pick < 58) begin
            queue_req(REQ_ACK, chip, 1'($urandom_range(1)), 8'($urandom), 16'($urandom));
         end else if (pick < 72) begin
            case ($urandom_range(3))
               0, 1: queue_req(REQ_WRITE, chip, PORT_CMD,
                               {EOI_NONSPECIFIC, 2'b00, 3'($urandom)}, 16'($urandom));
               2: queue_req(REQ_WRITE, chip, PORT_CMD,
                            {EOI_SPECIFIC, 2'b00, 3'($urandom)}, 16'($urandom));
               default: queue_req(REQ_WRITE, chip, PORT_CMD,
                                  {3'($urandom), 2'b00, 3'($urandom)}, 16'($urandom));
            endcase
         end else if (pick < 82) begin
            queue_req(REQ_WRITE, chip, PORT_CMD,
                      {3'($urandom), 1'b0, 1'b1, 3'($urandom)}, 16'($urandom));
         end else if (pick < 92) begin
            queue_req(REQ_READ, chip, 1'($urandom_range(1)), 8'($urandom), 16'($urandom));
         end else if (pick < 96) begin
            // Sparse masks keep most lines live.
            queue_req(REQ_WRITE, chip, PORT_DATA,
                      8'($urandom) & 8'($urandom) & 8'($urandom), 16'($urandom));
         end else begin
            queue_req(2'($urandom), chip, 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
